>>> design/assert_macros.svh
// Assertion macros shared by the UTF-8 name validator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/utf8nv_pkg.sv
// Types and constants shared by the UTF-8 name validator modules.
`default_nettype none

package utf8nv_pkg;

  localparam int CountWidth = 9;

  // Byte boundaries of the strict UTF-8 rules.
  localparam logic [7:0] BYTE_SPACE    = 8'h20;
  localparam logic [7:0] BYTE_DEL      = 8'h7F;
  localparam logic [7:0] LEAD2_LO      = 8'hC2;
  localparam logic [7:0] LEAD2_HI      = 8'hDF;
  localparam logic [7:0] LEAD3_LO      = 8'hE0;
  localparam logic [7:0] LEAD3_HI      = 8'hEF;
  localparam logic [7:0] LEAD4_LO      = 8'hF0;
  localparam logic [7:0] LEAD4_HI      = 8'hF4;
  localparam logic [7:0] CONT_LO       = 8'h80;
  localparam logic [7:0] CONT_HI       = 8'hBF;
  localparam logic [7:0] LEAD_E0       = 8'hE0;
  localparam logic [7:0] LEAD_ED       = 8'hED;
  localparam logic [7:0] LEAD_F0       = 8'hF0;
  localparam logic [7:0] LEAD_F4       = 8'hF4;
  localparam logic [7:0] E0_SECOND_MIN = 8'hA0;
  localparam logic [7:0] ED_SECOND_MAX = 8'h9F;
  localparam logic [7:0] F0_SECOND_MIN = 8'h90;
  localparam logic [7:0] F4_SECOND_MAX = 8'h8F;

  localparam logic [7:0] MAX_POINTS_RESET = 8'd64;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
  localparam logic [1:0] STATUS_REJECTED = 2'd2;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] byte_value;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [CountWidth-1:0] code_point_count;
    logic                  string_end;
  } result_t;

endpackage

`default_nettype wire

>>> design/utf8_name_validator_unit.sv
// Top level of the streaming strict UTF-8 name validator.
//
//  Channel  Dir  Handshake      Payload
//  s_axis   in   tvalid/tready  tdata: byte_value; tuser: has_byte; tlast: last_byte
//  m_axis   out  tvalid/tready  tdata: code_point_count; tuser: status; tlast: string_end
//  cfg      in   valid/ready    cfg_data: max_code_points (always ready)
//
// A word accepted on s_axis sits in the input register while the decoder
// checks it; its result then enters the output register and leaves on m_axis.
// One word per clock is sustained while m_axis_tready stays high: both
// registers reload in the cycle that their word moves on. A stall on m_axis
// holds the output word, then the input word, then drops s_axis_tready.
// Reset clears all string state and sets the limit to 64.
`default_nettype none

module utf8_name_validator_unit (
  input  wire         clk,
  input  wire         rst,
  // Input words.
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  wire         s_axis_tuser,   // [0] has_byte
  input  wire         s_axis_tlast,
  // Result words.
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [8:0] code_point_count, [15:9] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast,
  // Limit register write.
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_data
);
  import utf8nv_pkg::*;

  `include "assert_macros.svh"

  logic       in_valid;
  item_t      in_item;
  logic       out_free;
  logic       fire;
  result_t    step_result;
  logic [7:0] max_code_points;

  // The output register can take a new word when empty or being drained.
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign fire     = in_valid && out_free;

  utf8nv_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .take          (fire),
    .valid         (in_valid),
    .item          (in_item)
  );

  utf8nv_decoder u_decoder (
    .clk             (clk),
    .rst             (rst),
    .step_en         (fire),
    .item            (in_item),
    .max_code_points (max_code_points),
    .result          (step_result)
  );

  // Limit register; writes must arrive only while the block is idle; the block does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_code_points <= MAX_POINTS_RESET;
    end else if (cfg_valid) begin
      max_code_points <= cfg_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tdata <= {{(16 - CountWidth){1'b0}}, step_result.code_point_count};
      m_axis_tuser <= step_result.status;
      m_axis_tlast <= step_result.string_end;
    end
  end

  // A string verdict is never "fine so far", and a mid-string word is never
  // an acceptance.
  `ASSERT_ALWAYS(a_end_has_verdict, clk, rst,
                 !(m_axis_tvalid && m_axis_tlast) || m_axis_tuser != STATUS_OK)
  `ASSERT_ALWAYS(a_mid_not_accepted, clk, rst,
                 !(m_axis_tvalid && !m_axis_tlast) || m_axis_tuser != STATUS_ACCEPTED)
  `ASSERT_NEXT(a_fire_fills_output, clk, rst, fire, m_axis_tvalid)

endmodule

`default_nettype wire

>>> design/utf8nv_in_reg.sv
// Input register stage of the UTF-8 name validator.
`default_nettype none

module utf8nv_in_reg (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire  [7:0]            s_axis_tdata,
  input  wire                   s_axis_tlast,
  input  wire                   s_axis_tuser,
  input  wire                   take,
  output logic                  valid,
  output utf8nv_pkg::item_t     item
);
  import utf8nv_pkg::*;

  // The stage refills in the same cycle that the decoder consumes it.
  assign s_axis_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_axis_tready) begin
      valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.has_byte   <= s_axis_tuser;
      item.byte_value <= s_axis_tdata;
      item.last_byte  <= s_axis_tlast;
    end
  end

endmodule

`default_nettype wire

>>> design/utf8nv_decoder.sv
// Per-string UTF-8 decoding state and the per-byte check logic.
`default_nettype none

module utf8nv_decoder (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   step_en,
  input  utf8nv_pkg::item_t     item,
  input  wire  [7:0]            max_code_points,
  output utf8nv_pkg::result_t   result
);
  import utf8nv_pkg::*;

  `include "assert_macros.svh"

  logic [1:0]            bytes_remaining, bytes_remaining_next;
  logic [7:0]            lead_byte, lead_byte_next;
  logic                  expect_second, expect_second_next;
  logic                  rejected, rejected_next;
  logic [CountWidth-1:0] points_seen, points_seen_next;

  logic [CountWidth-1:0] points_inc;
  logic                  complete;
  logic                  second_bad;
  logic                  empty_str;
  logic                  bad_str;
  logic [7:0]            b;

  assign b          = item.byte_value;
  assign points_inc = points_seen + CountWidth'(1);

  // Overlong, surrogate and upper-range limits on the byte right after a lead.
  assign second_bad = (lead_byte == LEAD_E0 && b < E0_SECOND_MIN) ||
                      (lead_byte == LEAD_ED && b > ED_SECOND_MAX) ||
                      (lead_byte == LEAD_F0 && b < F0_SECOND_MIN) ||
                      (lead_byte == LEAD_F4 && b > F4_SECOND_MAX);

  always_comb begin
    bytes_remaining_next = bytes_remaining;
    lead_byte_next       = lead_byte;
    expect_second_next   = expect_second;
    rejected_next        = rejected;
    points_seen_next     = points_seen;
    complete             = 1'b0;

    if (item.has_byte && !rejected) begin
      if (bytes_remaining == 2'd0) begin
        if (b <= BYTE_DEL) begin
          if (b < BYTE_SPACE || b == BYTE_DEL) begin
            rejected_next = 1'b1;
          end else begin
            complete = 1'b1;
          end
        end else if (b inside {[LEAD2_LO:LEAD2_HI]}) begin
          bytes_remaining_next = 2'd1;
          lead_byte_next       = b;
          expect_second_next   = 1'b1;
        end else if (b inside {[LEAD3_LO:LEAD3_HI]}) begin
          bytes_remaining_next = 2'd2;
          lead_byte_next       = b;
          expect_second_next   = 1'b1;
        end else if (b inside {[LEAD4_LO:LEAD4_HI]}) begin
          bytes_remaining_next = 2'd3;
          lead_byte_next       = b;
          expect_second_next   = 1'b1;
        end else begin
          rejected_next = 1'b1;
        end
      end else if (!(b inside {[CONT_LO:CONT_HI]})) begin
        rejected_next = 1'b1;
      end else if (expect_second && second_bad) begin
        rejected_next = 1'b1;
      end else begin
        expect_second_next   = 1'b0;
        bytes_remaining_next = bytes_remaining - 2'd1;
        complete             = (bytes_remaining == 2'd1);
      end
    end

    // A finished code point counts even when it breaks the limit.
    if (complete) begin
      points_seen_next = points_inc;
      if (points_inc > {1'b0, max_code_points}) begin
        rejected_next = 1'b1;
      end
    end
  end

  assign empty_str = !rejected_next && bytes_remaining_next == 2'd0 &&
                     points_seen_next == '0;
  assign bad_str   = rejected_next || bytes_remaining_next != 2'd0 || empty_str;

  always_comb begin
    result.code_point_count = points_seen_next;
    result.string_end       = item.last_byte;
    if (item.last_byte) begin
      result.status = bad_str ? STATUS_REJECTED : STATUS_ACCEPTED;
    end else begin
      result.status = rejected_next ? STATUS_REJECTED : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= 2'd0;
      lead_byte       <= 8'd0;
      expect_second   <= 1'b0;
      rejected        <= 1'b0;
      points_seen     <= '0;
    end else if (step_en) begin
      if (item.last_byte) begin
        bytes_remaining <= 2'd0;
        lead_byte       <= 8'd0;
        expect_second   <= 1'b0;
        rejected        <= 1'b0;
        points_seen     <= '0;
      end else begin
        bytes_remaining <= bytes_remaining_next;
        lead_byte       <= lead_byte_next;
        expect_second   <= expect_second_next;
        rejected        <= rejected_next;
        points_seen     <= points_seen_next;
      end
    end
  end

  `ASSERT_ALWAYS(a_second_needs_pending, clk, rst,
                 !expect_second || bytes_remaining != 2'd0)
  `ASSERT_ALWAYS(a_count_bounded, clk, rst, points_seen <= 9'd256)
  `ASSERT_NEXT(a_clear_after_last, clk, rst, step_en && item.last_byte,
               points_seen == '0 && !rejected && bytes_remaining == 2'd0)

endmodule

`default_nettype wire
